### rtl/core/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tps check failed");

// Next-cycle implication, switched off while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tps check failed");

`endif

### rtl/core/tps_pkg.sv
`timescale 1ns / 1ps
package tps_pkg;

   localparam int COORD_W    = 32;
   localparam int FRAC_BITS  = 16;
   localparam int T_BITS     = 32;
   localparam int DIFF_W     = COORD_W + 1;
   localparam int PROD_W     = 2 * COORD_W + 1;
   localparam int DIST_W     = 2 * COORD_W + 3;
   localparam int DEN_W      = 2 * COORD_W + 4;
   localparam int FRAC_W     = T_BITS + 1;
   localparam int DIV_STEPS  = 2;
   localparam int DIV_TOTAL  = T_BITS + 1;
   localparam int DIV_STAGES = (DIV_TOTAL + DIV_STEPS - 1) / DIV_STEPS;
   localparam int SPAN_W     = COORD_W + 1;
   localparam int CPROD_W    = SPAN_W + FRAC_W + 1;
   localparam int STEP_W     = CPROD_W - T_BITS;
   localparam int SUM_W      = STEP_W + 1;
   localparam int CSR_IDX_W  = 3;

   localparam logic [CSR_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_NORMAL_X = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_NORMAL_Y = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_NORMAL_Z = 3'd5;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [SPAN_W-1:0]  span_type;
   typedef logic [DEN_W-1:0]          den_type;
   typedef logic [FRAC_W-1:0]         frac_type;

   typedef struct packed {
      coord_type vertex_a_x;
      coord_type vertex_a_y;
      coord_type vertex_a_z;
      coord_type vertex_b_x;
      coord_type vertex_b_y;
      coord_type vertex_b_z;
      coord_type vertex_c_x;
      coord_type vertex_c_y;
      coord_type vertex_c_z;
   } req_type;

   typedef struct packed {
      logic      side_below;
      coord_type corner0_x;
      coord_type corner0_y;
      coord_type corner0_z;
      coord_type corner1_x;
      coord_type corner1_y;
      coord_type corner1_z;
      coord_type corner2_x;
      coord_type corner2_y;
      coord_type corner2_z;
      logic      final_piece;
   } rsp_type;

   // Context carried alongside the divider.
   typedef struct packed {
      logic [2:0]            below;
      coord_type [2:0][2:0]  verts;
      coord_type [1:0][2:0]  base;
      span_type  [1:0][2:0]  span;
   } ctx_type;

endpackage

### rtl/core/tps_divider.sv
`timescale 1ns / 1ps
// Restoring divider, DIV_STEPS quotient bits per stage, floor(2^T * num / den).
module tps_divider import tps_pkg::*; (
   input  logic     clock,
   input  logic     en,
   input  den_type  num,
   input  den_type  den,
   output frac_type quot
);

   logic [DEN_W:0] rem_ff [DIV_STAGES];
   logic [DEN_W:0] rem_in [DIV_STAGES];
   den_type        den_ff [DIV_STAGES];
   den_type        den_in [DIV_STAGES];
   frac_type       q_ff   [DIV_STAGES];
   frac_type       q_in   [DIV_STAGES];

   always_comb begin
      logic [DEN_W:0] r;
      frac_type       q;
      den_type        d;
      for (int s = 0; s < DIV_STAGES; s++) begin
         if (s == 0) begin
            r = {1'b0, num};
            q = '0;
            d = den;
         end else begin
            r = rem_ff[s-1];
            q = q_ff[s-1];
            d = den_ff[s-1];
         end
         for (int k = 0; k < DIV_STEPS; k++) begin
            if (s * DIV_STEPS + k < DIV_TOTAL) begin
               if (s * DIV_STEPS + k != 0) begin
                  r = {r[DEN_W-1:0], 1'b0};
               end
               q = {q[FRAC_W-2:0], 1'b0};
               if (r >= {1'b0, d}) begin
                  r    = r - {1'b0, d};
                  q[0] = 1'b1;
               end
            end
         end
         rem_in[s] = r;
         q_in[s]   = q;
         den_in[s] = d;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_in;
         q_ff   <= q_in;
         den_ff <= den_in;
      end
   end

   assign quot = q_ff[DIV_STAGES-1];

endmodule

### rtl/core/triangle_plane_split.sv
`timescale 1ns / 1ps
// Channel    | Ports                          | Direction | Handshake
// request    | start, busy, req_item          | in        | taken when start & !busy
// result     | rsp_valid, rsp_item            | out       | one-cycle strobe, no stall
// config     | csr_we, csr_index, csr_data    | in        | written when csr_we
//
// A request passes the capture, offset, product, distance and operand stages, the divider
// stages, then scale, round and the result register. A pass-through triangle gives one
// result; a crossing triangle gives three on consecutive cycles, holding busy while the
// last two drain, and the whole pipeline holds while they do.
// Synchronous reset clears valid bits and the piece queue, and sets the plane to a zero origin with a unit z normal.
// The result side cannot stall; busy only reflects the piece queue draining.
module triangle_plane_split import tps_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  req_type              req_item,
   output logic                 rsp_valid,
   output rsp_type              rsp_item,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  coord_type            csr_data
);

   typedef struct packed {
      logic [1:0] u0;
      logic [1:0] u1;
      logic [1:0] l0;
      logic [1:0] l1;
      logic       two_up;
   } sel_type;

   // Lists above/below vertices in A, B, C order.
   function automatic sel_type pick(input logic [2:0] below);
      sel_type s;
      int      nu;
      int      nd;
      s  = '0;
      nu = 0;
      nd = 0;
      for (int i = 0; i < 3; i++) begin
         if (!below[i]) begin
            if (nu == 0) s.u0 = 2'(i);
            else         s.u1 = 2'(i);
            nu++;
         end else begin
            if (nd == 0) s.l0 = 2'(i);
            else         s.l1 = 2'(i);
            nd++;
         end
      end
      s.two_up = (nu == 2);
      return s;
   endfunction

   function automatic rsp_type mk(input logic side, input coord_type [2:0] c0,
                                  input coord_type [2:0] c1, input coord_type [2:0] c2,
                                  input logic fin);
      rsp_type r;
      r.side_below  = side;
      r.corner0_x   = c0[0];
      r.corner0_y   = c0[1];
      r.corner0_z   = c0[2];
      r.corner1_x   = c1[0];
      r.corner1_y   = c1[1];
      r.corner1_z   = c1[2];
      r.corner2_x   = c2[0];
      r.corner2_y   = c2[1];
      r.corner2_z   = c2[2];
      r.final_piece = fin;
      return r;
   endfunction

   function automatic coord_type sat(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] hi;
      logic signed [SUM_W-1:0] lo;
      hi = SUM_W'({1'b0, {(COORD_W-1){1'b1}}});
      lo = -hi - SUM_W'(1);
      if (v > hi)      return hi[COORD_W-1:0];
      else if (v < lo) return lo[COORD_W-1:0];
      else             return v[COORD_W-1:0];
   endfunction

   // plane registers
   coord_type [2:0] origin_ff;
   coord_type [2:0] normal_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_ff <= '0;
         normal_ff <= {coord_type'(COORD_W'(1) << FRAC_BITS), coord_type'(0),
                       coord_type'(0)};
      end else if (csr_we) begin
         unique case (csr_index)
            REG_ORIGIN_X: origin_ff[0] <= csr_data;
            REG_ORIGIN_Y: origin_ff[1] <= csr_data;
            REG_ORIGIN_Z: origin_ff[2] <= csr_data;
            REG_NORMAL_X: normal_ff[0] <= csr_data;
            REG_NORMAL_Y: normal_ff[1] <= csr_data;
            REG_NORMAL_Z: normal_ff[2] <= csr_data;
            default: ;
         endcase
      end
   end

   logic adv;
   logic take;
   assign take = start && !busy;

   // stage 1: request capture
   logic    v1_ff;
   req_type req1_ff;
   coord_type [2:0][2:0] verts1;

   always_comb begin
      verts1[0] = {req1_ff.vertex_a_z, req1_ff.vertex_a_y, req1_ff.vertex_a_x};
      verts1[1] = {req1_ff.vertex_b_z, req1_ff.vertex_b_y, req1_ff.vertex_b_x};
      verts1[2] = {req1_ff.vertex_c_z, req1_ff.vertex_c_y, req1_ff.vertex_c_x};
   end

   // stage 2: offsets from the plane origin
   logic v2_ff;
   coord_type [2:0][2:0]                      verts2_ff;
   logic signed [2:0][2:0][DIFF_W-1:0]        diff2_ff;
   logic signed [2:0][2:0][DIFF_W-1:0]        diff2_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int k = 0; k < 3; k++) begin
            diff2_in[i][k] = {verts1[i][k][COORD_W-1], verts1[i][k]}
                           - {origin_ff[k][COORD_W-1], origin_ff[k]};
         end
      end
   end

   // stage 3: per-axis products
   logic v3_ff;
   coord_type [2:0][2:0]                verts3_ff;
   logic signed [2:0][2:0][PROD_W-1:0]  prod3_ff;
   logic signed [2:0][2:0][PROD_W-1:0]  prod3_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int k = 0; k < 3; k++) begin
            prod3_in[i][k] = PROD_W'($signed(normal_ff[k]) * $signed(diff2_ff[i][k]));
         end
      end
   end

   // stage 4: signed distances, exact
   logic v4_ff;
   coord_type [2:0][2:0]               verts4_ff;
   logic signed [2:0][DIST_W-1:0]      dist4_ff;
   logic signed [2:0][DIST_W-1:0]      dist4_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dist4_in[i] = DIST_W'($signed(prod3_ff[i][0])) + DIST_W'($signed(prod3_ff[i][1]))
                     + DIST_W'($signed(prod3_ff[i][2]));
      end
   end

   // stage 5: pick the two cut edges, form divider operands
   logic     v5_ff;
   ctx_type  ctx5_ff;
   ctx_type  ctx5_in;
   den_type  [1:0] num5_ff;
   den_type  [1:0] den5_ff;
   den_type  [1:0] num5_in;
   den_type  [1:0] den5_in;

   always_comb begin
      sel_type    s;
      logic [2:0] b;
      logic [1:0] pi [2];
      logic [1:0] qi [2];
      den_type    dp;
      den_type    dq;
      for (int i = 0; i < 3; i++) b[i] = dist4_ff[i][DIST_W-1];
      s     = pick(b);
      pi[0] = s.u0;
      qi[0] = s.l0;
      pi[1] = s.two_up ? s.u1 : s.u0;
      qi[1] = s.two_up ? s.l0 : s.l1;
      ctx5_in.below = b;
      ctx5_in.verts = verts4_ff;
      for (int c = 0; c < 2; c++) begin
         dp = DEN_W'($signed(dist4_ff[pi[c]]));
         dq = DEN_W'($signed(dist4_ff[qi[c]]));
         num5_in[c] = -dq;
         den5_in[c] = dp - dq;
         ctx5_in.base[c] = verts4_ff[qi[c]];
         for (int k = 0; k < 3; k++) begin
            ctx5_in.span[c][k] = {verts4_ff[pi[c]][k][COORD_W-1], verts4_ff[pi[c]][k]}
                               - {verts4_ff[qi[c]][k][COORD_W-1], verts4_ff[qi[c]][k]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= take;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         req1_ff   <= req_item;
         verts2_ff <= verts1;
         diff2_ff  <= diff2_in;
         verts3_ff <= verts2_ff;
         prod3_ff  <= prod3_in;
         verts4_ff <= verts3_ff;
         dist4_ff  <= dist4_in;
         ctx5_ff   <= ctx5_in;
         num5_ff   <= num5_in;
         den5_ff   <= den5_in;
      end
   end

   // divider section: two lanes, context delayed alongside
   frac_type [1:0] quot;
   logic    vd_ff   [DIV_STAGES];
   ctx_type ctxd_ff [DIV_STAGES];

   for (genvar c = 0; c < 2; c++) begin : g_div
      tps_divider u_div (
         .clock (clock),
         .en    (adv),
         .num   (num5_ff[c]),
         .den   (den5_ff[c]),
         .quot  (quot[c])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < DIV_STAGES; s++) vd_ff[s] <= 1'b0;
      end else if (adv) begin
         vd_ff[0] <= v5_ff;
         for (int s = 1; s < DIV_STAGES; s++) vd_ff[s] <= vd_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ctxd_ff[0] <= ctx5_ff;
         for (int s = 1; s < DIV_STAGES; s++) ctxd_ff[s] <= ctxd_ff[s-1];
      end
   end

   // scale the edge spans by t
   logic    vm_ff;
   ctx_type ctxm_ff;
   logic signed [1:0][2:0][CPROD_W-1:0] cprod_ff;
   logic signed [1:0][2:0][CPROD_W-1:0] cprod_in;

   always_comb begin
      for (int c = 0; c < 2; c++) begin
         for (int k = 0; k < 3; k++) begin
            cprod_in[c][k] = CPROD_W'($signed(ctxd_ff[DIV_STAGES-1].span[c][k])
                                      * $signed({1'b0, quot[c]}));
         end
      end
   end

   // round half up, add to base vertex, saturate
   logic    vr_ff;
   ctx_type ctxr_ff;
   coord_type [1:0][2:0] cut_ff;
   coord_type [1:0][2:0] cut_in;

   always_comb begin
      logic signed [CPROD_W-1:0] rs;
      logic signed [STEP_W-1:0]  st;
      logic signed [SUM_W-1:0]   sm;
      for (int c = 0; c < 2; c++) begin
         for (int k = 0; k < 3; k++) begin
            rs = cprod_ff[c][k] + (CPROD_W'(1) << (T_BITS - 1));
            st = rs[CPROD_W-1:T_BITS];
            sm = SUM_W'($signed(ctxm_ff.base[c][k])) + SUM_W'(st);
            cut_in[c][k] = sat(sm);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vm_ff <= 1'b0;
         vr_ff <= 1'b0;
      end else if (adv) begin
         vm_ff <= vd_ff[DIV_STAGES-1];
         vr_ff <= vm_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ctxm_ff  <= ctxd_ff[DIV_STAGES-1];
         cprod_ff <= cprod_in;
         ctxr_ff  <= ctxm_ff;
         cut_ff   <= cut_in;
      end
   end

   // piece assembly and result queue
   rsp_type    pend_ff [2];
   rsp_type    pend_in [2];
   logic [1:0] pend_cnt_ff;
   logic [1:0] pend_cnt_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   rsp_type    rsp_ff;
   rsp_type    rsp_in;

   assign adv  = (pend_cnt_ff == 2'd0);
   assign busy = !adv;

   always_comb begin
      sel_type    s;
      logic [2:0] b;
      logic       pass;
      rsp_type    p0;
      rsp_type    p1;
      rsp_type    p2;
      b    = ctxr_ff.below;
      s    = pick(b);
      pass = (b == 3'b000) || (b == 3'b111);
      if (pass) begin
         p0 = mk(b[0], ctxr_ff.verts[0], ctxr_ff.verts[1], ctxr_ff.verts[2], 1'b1);
      end else begin
         p0 = mk(1'b0, ctxr_ff.verts[s.u0], cut_ff[0], cut_ff[1], 1'b0);
      end
      p1 = mk(1'b1, ctxr_ff.verts[s.l0], cut_ff[1], cut_ff[0], 1'b0);
      if (s.two_up) begin
         p2 = mk(1'b0, ctxr_ff.verts[s.u1], ctxr_ff.verts[s.u0], cut_ff[1], 1'b1);
      end else begin
         p2 = mk(1'b1, ctxr_ff.verts[s.l0], ctxr_ff.verts[s.l1], cut_ff[1], 1'b1);
      end

      pend_in      = pend_ff;
      pend_cnt_in  = pend_cnt_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      if (pend_cnt_ff != 2'd0) begin
         rsp_in       = pend_ff[0];
         rsp_valid_in = 1'b1;
         pend_in[0]   = pend_ff[1];
         pend_cnt_in  = pend_cnt_ff - 2'd1;
      end else if (vr_ff) begin
         rsp_in       = p0;
         rsp_valid_in = 1'b1;
         if (!pass) begin
            pend_in[0]  = p1;
            pend_in[1]  = p2;
            pend_cnt_in = 2'd2;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_cnt_ff  <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_cnt_ff  <= pend_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

### rtl/core/tps_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tps_checker import tps_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    busy,
   input logic    rsp_valid,
   input rsp_type rsp_item
);

   logic mid_piece;
   assign mid_piece = rsp_valid && !rsp_item.final_piece;

   // pieces of a split triangle come back to back
   `ASSERT_NEXT(a_pieces_contiguous, clock, reset, mid_piece, rsp_valid)

   // the first piece is above, the second below
   `ASSERT_NEXT(a_second_below, clock, reset, mid_piece && !rsp_item.side_below, mid_piece && rsp_item.side_below)

   // busy only while a split triangle is still draining
   `ASSERT_IMPLY(a_busy_draining, clock, reset, busy, mid_piece)

endmodule

bind triangle_plane_split tps_checker u_tps_checker (.*);

### tb/sv/tb_triangle_plane_split.sv
`timescale 1ns / 1ps
module tb_triangle_plane_split;
   import tps_pkg::*;

   localparam int LATENCY = 8 + DIV_STAGES;
   localparam longint CYCLE_LIMIT = 400000;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   req_type              req_item = '0;
   logic                 rsp_valid;
   rsp_type              rsp_item;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = REG_ORIGIN_X;
   coord_type            csr_data = '0;

   // Plane as the block should hold it: origin then normal, register order.
   coord_type plane_reg [6];
   rsp_type   pending_pieces [$];
   int        mismatches = 0;
   longint    cycle_count = 0;
   bit        no_gaps = 1'b0;

   triangle_plane_split uut (.*);

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // --- predictor -------------------------------------------------------

   // Exact signed distance of a vertex from the plane (fits comfortably in 80 bits).
   function automatic logic signed [79:0] plane_distance(input coord_type px, py, pz);
      logic signed [79:0] acc;
      acc = 80'(plane_reg[3]) * (80'(px) - 80'(plane_reg[0]));
      acc = acc + 80'(plane_reg[4]) * (80'(py) - 80'(plane_reg[1]));
      acc = acc + 80'(plane_reg[5]) * (80'(pz) - 80'(plane_reg[2]));
      return acc;
   endfunction

   // Point on edge P(above)->Q(below) where it meets the plane.
   function automatic void edge_cut(input coord_type p [3], q [3],
                                    input logic signed [79:0] dp, dq,
                                    output coord_type cut [3]);
      logic [111:0]        num;
      logic [111:0]        den;
      logic [111:0]        tq;
      logic signed [111:0] prod;
      logic signed [79:0]  step;
      logic signed [79:0]  sum;
      num = 112'(-dq);
      den = 112'(dp - dq);
      tq  = (num << T_BITS) / den;  // truncated 32-bit fraction, at most 1.0
      for (int k = 0; k < 3; k++) begin
         prod = (112'(p[k]) - 112'(q[k])) * $signed({1'b0, tq[110:0]});
         prod = prod + (112'sd1 <<< (T_BITS - 1));
         step = 80'(prod >>> T_BITS);
         sum  = 80'(q[k]) + step;
         if (sum > 80'sd2147483647) sum = 80'sd2147483647;
         if (sum < -80'sd2147483648) sum = -80'sd2147483648;
         cut[k] = coord_type'(sum);
      end
   endfunction

   function automatic rsp_type make_piece(input logic below, input coord_type c0 [3],
                                          c1 [3], c2 [3], input logic last);
      rsp_type r;
      r.side_below = below;
      r.corner0_x = c0[0]; r.corner0_y = c0[1]; r.corner0_z = c0[2];
      r.corner1_x = c1[0]; r.corner1_y = c1[1]; r.corner1_z = c1[2];
      r.corner2_x = c2[0]; r.corner2_y = c2[1]; r.corner2_z = c2[2];
      r.final_piece = last;
      return r;
   endfunction

   // Append one expected piece at the tail of the queue.
   function automatic void queue_piece(input rsp_type piece);
      pending_pieces.insert(pending_pieces.size(), piece);
   endfunction

   task automatic predict_pieces(input req_type tri_in);
      coord_type          vtx [3][3];
      logic signed [79:0] dvals [3];
      int                 above_idx [3];
      int                 below_idx [3];
      int                 n_above;
      int                 n_below;
      int                 n_cut;
      coord_type          cuts [2][3];
      coord_type          tmp [3];
      n_above = 0; n_below = 0; n_cut = 0;
      vtx[0] = '{tri_in.vertex_a_x, tri_in.vertex_a_y, tri_in.vertex_a_z};
      vtx[1] = '{tri_in.vertex_b_x, tri_in.vertex_b_y, tri_in.vertex_b_z};
      vtx[2] = '{tri_in.vertex_c_x, tri_in.vertex_c_y, tri_in.vertex_c_z};
      for (int i = 0; i < 3; i++) begin
         dvals[i] = plane_distance(vtx[i][0], vtx[i][1], vtx[i][2]);
         if (dvals[i] < 0) below_idx[n_below++] = i;
         else above_idx[n_above++] = i;
      end
      if (n_below == 0 || n_above == 0) begin
         queue_piece(make_piece(n_above == 0, vtx[0], vtx[1], vtx[2], 1'b1));
         return;
      end
      // above vertex outer, below vertex inner; a third cut would overwrite the first
      for (int a = 0; a < n_above; a++)
         for (int b = 0; b < n_below; b++) begin
            edge_cut(vtx[above_idx[a]], vtx[below_idx[b]], dvals[above_idx[a]],
                     dvals[below_idx[b]], tmp);
            cuts[n_cut & 1] = tmp;
            n_cut++;
         end
      queue_piece(make_piece(1'b0, vtx[above_idx[0]], cuts[0], cuts[1], 1'b0));
      queue_piece(make_piece(1'b1, vtx[below_idx[0]], cuts[1], cuts[0], 1'b0));
      if (n_above == 2)
         queue_piece(make_piece(1'b0, vtx[above_idx[1]], vtx[above_idx[0]],
                                cuts[1], 1'b1));
      else
         queue_piece(make_piece(1'b1, vtx[below_idx[0]], vtx[below_idx[1]],
                                cuts[1], 1'b1));
   endtask

   // --- result checker --------------------------------------------------

   always @(posedge clock) begin
      rsp_type exp_piece;
      if (!reset && rsp_valid) begin
         if (pending_pieces.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected piece %h at cycle %0d", rsp_item, cycle_count);
         end else begin
            exp_piece = pending_pieces.pop_front();
            if (rsp_item !== exp_piece) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("piece mismatch at cycle %0d", cycle_count);
                  $display("  exp side %b c0 %h %h %h c1 %h %h %h c2 %h %h %h last %b",
                     exp_piece.side_below, exp_piece.corner0_x, exp_piece.corner0_y,
                     exp_piece.corner0_z, exp_piece.corner1_x, exp_piece.corner1_y,
                     exp_piece.corner1_z, exp_piece.corner2_x, exp_piece.corner2_y,
                     exp_piece.corner2_z, exp_piece.final_piece);
                  $display("  got side %b c0 %h %h %h c1 %h %h %h c2 %h %h %h last %b",
                     rsp_item.side_below, rsp_item.corner0_x, rsp_item.corner0_y,
                     rsp_item.corner0_z, rsp_item.corner1_x, rsp_item.corner1_y,
                     rsp_item.corner1_z, rsp_item.corner2_x, rsp_item.corner2_y,
                     rsp_item.corner2_z, rsp_item.final_piece);
               end
            end
         end
      end
   end

   // --- drivers ---------------------------------------------------------

   // Send one triangle request; random gaps unless a gap-free stretch runs.
   // start is left high after the accepting edge; the next send or wait_idle
   // drives it in the same step.
   task automatic send_triangle(input req_type tri_in);
      while (!no_gaps && $urandom_range(99) < 28) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= tri_in;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_pieces(tri_in);
   endtask

   // Drain, then let the pipeline empty (pass-through always yields a piece,
   // but a margin costs nothing).
   task automatic wait_idle();
      start <= 1'b0;
      while (pending_pieces.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_plane(input coord_type ox, oy, oz, nx, ny, nz);
      coord_type vals [6];
      vals = '{ox, oy, oz, nx, ny, nz};
      wait_idle();
      for (int i = 0; i < 6; i++) begin
         csr_we    <= 1'b1;
         csr_index <= CSR_IDX_W'(i);
         csr_data  <= vals[i];
         @(posedge clock);
         plane_reg[i] = vals[i];
      end
      // index above 5 must be ignored
      csr_index <= 3'd7;
      csr_data  <= $urandom;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic req_type tri_of(input coord_type v [9]);
      return {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8]};
   endfunction

   // Small coordinates around the plane so most triangles cross.
   function automatic coord_type near_coord();
      return coord_type'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
   endfunction

   function automatic coord_type any_coord();
      case ($urandom_range(3))
         0: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         1: return $urandom;
         default: return near_coord();
      endcase
   endfunction

   // --- tests -----------------------------------------------------------

   task automatic test_reset_plane();
      // z = 0 plane at reset: on the plane (counts as above), all below, then two mixed.
      send_triangle(tri_of('{0, 0, 0, 32'sh10000, 0, 0, 0, 32'sh10000, 0}));
      send_triangle(tri_of('{0, 0, -1, 5, 0, -7, 0, 9, 32'sh8000_0000}));
      send_triangle(tri_of('{0, 0, 32'sh20000, 32'sh10000, 0, -32'sh10000,
                             0, 32'sh10000, 32'sh10000}));
      send_triangle(tri_of('{0, 0, -32'sh20000, 32'sh10000, 0, 32'sh10000,
                             0, 32'sh10000, -32'sh10000}));
   endtask

   task automatic test_extremes();
      coord_type mx, mn;
      mx = 32'sh7FFF_FFFF; mn = 32'sh8000_0000;
      write_plane(mx, mn, mx, mx, mn, mx);
      send_triangle(tri_of('{mx, mx, mx, mn, mn, mn, mx, mn, mx}));
      send_triangle(tri_of('{mn, mx, mn, mx, mn, mx, mn, mn, mn}));
      write_plane(0, 0, 0, mn, mn, mn);
      send_triangle(tri_of('{mx, mn, mx, mn, mx, mn, 1, -1, 0}));
      send_triangle(tri_of('{mx, mx, mx, mn, mn, mn, 0, 0, 0}));
      send_triangle(tri_of('{mn, mx, 0, mx, mn, 0, mx, mx, mn}));
      // zero normal: everything passes through above
      write_plane(5, 5, 5, 0, 0, 0);
      send_triangle(tri_of('{mx, mn, 0, 1, 2, 3, mn, mn, mn}));
      // degenerate triangles through a tilted plane
      write_plane(0, 0, 0, 32'sh10000, 32'sh10000, 0);
      send_triangle(tri_of('{32'sh10000, 0, 0, 32'sh10000, 0, 0, -32'sh30000, 0, 0}));
      send_triangle(tri_of('{-32'sh10000, 0, 0, 5, 5, 5, -32'sh10000, 0, 0}));
   endtask

   task automatic test_random_planes();
      coord_type v [9];
      for (int phase = 0; phase < 6; phase++) begin
         write_plane(near_coord(), near_coord(), near_coord(),
                     phase == 5 ? any_coord() : near_coord(),
                     near_coord(), phase == 4 ? any_coord() : near_coord());
         no_gaps = (phase == 2);
         for (int n = 0; n < 28; n++) begin
            for (int k = 0; k < 9; k++)
               v[k] = ($urandom_range(9) < 8) ? near_coord() : any_coord();
            send_triangle(tri_of(v));
         end
         no_gaps = 1'b0;
      end
   endtask

   initial begin
      plane_reg = '{0, 0, 0, 0, 0, 32'sh0001_0000};
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_plane();
      test_extremes();
      test_random_planes();
      wait_idle();
      if (mismatches == 0 && pending_pieces.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
